// File: sv/tlshsp_pkg.sv
package tlshsp_pkg;

	localparam int MAX_SPLITS = 4;

	localparam int CAND_W   = 16;
	localparam int SPLIT_W  = 14;
	localparam int PLEN_W   = 15;
	localparam int DELAY_W  = 17;
	localparam int BASE_W   = 16;
	localparam int COUNT_W  = 3;
	localparam int CHUNK_W  = 3;

	localparam logic [CAND_W-1:0]  HDR_BYTES      = 16'd5;
	localparam logic [PLEN_W-1:0]  MAX_PAYLOAD    = 15'd16384;
	localparam logic [PLEN_W-1:0]  MIN_PAYLOAD    = 15'd2;
	localparam logic [DELAY_W-1:0] SLOW_MIN_DELAY = 17'd40;
	localparam logic [CHUNK_W-1:0] SLOW_CHUNK     = 3'd4;
	localparam logic [CAND_W-1:0]  FIRST_BYTE     = 16'd1;

	// Profile codes carried in func.
	localparam logic [3:0] FUNC_NONE         = 4'd0;
	localparam logic [3:0] FUNC_SNI_MID      = 4'd1;
	localparam logic [3:0] FUNC_RECORD_1     = 4'd2;
	localparam logic [3:0] FUNC_PACKET_FIRST = 4'd3;
	localparam logic [3:0] FUNC_PACKET_LAST  = 4'd7;
	localparam logic [3:0] FUNC_SNI_PRE      = 4'd8;
	localparam logic [3:0] FUNC_SNI_MULTI    = 4'd9;
	localparam logic [3:0] FUNC_PACKET_ALT   = 4'd10;
	localparam logic [3:0] FUNC_SNI_MID_SLOW = 4'd11;

	typedef enum logic [1:0] {
		PLAN_REJECT = 2'd0,
		PLAN_PASS   = 2'd1,
		PLAN_SPLIT  = 2'd2
	} plan_kind_t;

	typedef logic [CAND_W-1:0] cand_t;

	typedef struct packed {
		plan_kind_t                 kind;
		cand_t [MAX_SPLITS-1:0]     cand;
		logic [MAX_SPLITS-1:0]      cand_mask;
		logic [PLEN_W-1:0]          plen;
		logic [CHUNK_W-1:0]         chunk;
		logic [DELAY_W-1:0]         delay;
	} plan_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: sv/tlshsp_ifs.sv
interface tlshsp_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic        spans_records;
	logic        has_sni;
	logic [14:0] sni_offset;
	logic [7:0]  sni_length;
	logic [14:0] payload_length;

	modport source(output valid, func, spans_records, has_sni, sni_offset, sni_length,
		payload_length, input ready);
	modport sink(input valid, func, spans_records, has_sni, sni_offset, sni_length,
		payload_length, output ready);
endinterface

interface tlshsp_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  split_count;
	logic [13:0] split_a;
	logic [13:0] split_b;
	logic [13:0] split_c;
	logic [13:0] split_d;
	logic [2:0]  write_chunk;
	logic [16:0] delay_ms;

	modport source(output valid, accepted, split_count, split_a, split_b, split_c, split_d,
		write_chunk, delay_ms, input ready);
	modport sink(input valid, accepted, split_count, split_a, split_b, split_c, split_d,
		write_chunk, delay_ms, output ready);
endinterface

interface tlshsp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] base_delay_ms;

	modport source(output valid, base_delay_ms, input ready);
	modport sink(input valid, base_delay_ms, output ready);
endinterface

// File: sv/tlshsp_front.sv
module tlshsp_front (
	tlshsp_in_if.sink                              hello,
	input  logic [tlshsp_pkg::BASE_W-1:0]          base_delay,
	input  tlshsp_pkg::q_status_t                  q_status,
	output logic                                   push,
	output tlshsp_pkg::plan_entry_t                entry
);

	logic                              needs_sni;
	logic                              passthrough;
	logic                              unknown;
	logic                              early_exit;
	logic [tlshsp_pkg::CAND_W-1:0]     start_w;
	logic [tlshsp_pkg::CAND_W-1:0]     mid_w;
	logic [tlshsp_pkg::CAND_W-1:0]     end_w;
	logic [tlshsp_pkg::DELAY_W-1:0]    slow_delay;

	assign hello.ready = !q_status.full;
	assign push        = hello.valid && !q_status.full;

	assign needs_sni = (hello.func == tlshsp_pkg::FUNC_SNI_MID) ||
		(hello.func == tlshsp_pkg::FUNC_SNI_PRE) ||
		(hello.func == tlshsp_pkg::FUNC_SNI_MULTI) ||
		(hello.func == tlshsp_pkg::FUNC_SNI_MID_SLOW);
	assign passthrough = (hello.func == tlshsp_pkg::FUNC_NONE) ||
		((hello.func >= tlshsp_pkg::FUNC_PACKET_FIRST) &&
		 (hello.func <= tlshsp_pkg::FUNC_PACKET_LAST)) ||
		(hello.func == tlshsp_pkg::FUNC_PACKET_ALT);
	assign unknown    = hello.func > tlshsp_pkg::FUNC_SNI_MID_SLOW;
	assign early_exit = hello.spans_records || (needs_sni && !hello.has_sni) ||
		(hello.payload_length < tlshsp_pkg::MIN_PAYLOAD);

	// The hostname offset includes the record header; below it the start clamps to zero.
	always_comb begin
		if (hello.has_sni && ({1'b0, hello.sni_offset} >= tlshsp_pkg::HDR_BYTES)) begin
			start_w = {1'b0, hello.sni_offset} - tlshsp_pkg::HDR_BYTES;
		end else begin
			start_w = '0;
		end
	end

	assign mid_w = start_w + {9'd0, hello.sni_length[7:1]};
	assign end_w = start_w + {8'd0, hello.sni_length};

	always_comb begin
		slow_delay = {base_delay, 1'b0};
		if (slow_delay < tlshsp_pkg::SLOW_MIN_DELAY) begin
			slow_delay = tlshsp_pkg::SLOW_MIN_DELAY;
		end
	end

	always_comb begin
		entry           = '0;
		entry.kind      = tlshsp_pkg::PLAN_REJECT;
		entry.delay     = {1'b0, base_delay};
		if (hello.payload_length > tlshsp_pkg::MAX_PAYLOAD) begin
			entry.plen = tlshsp_pkg::MAX_PAYLOAD;
		end else begin
			entry.plen = hello.payload_length;
		end
		priority if (unknown) begin
			entry.kind = tlshsp_pkg::PLAN_REJECT;
		end else if (passthrough) begin
			entry.kind = tlshsp_pkg::PLAN_PASS;
		end else if (early_exit) begin
			entry.kind = tlshsp_pkg::PLAN_REJECT;
		end else begin
			entry.kind = tlshsp_pkg::PLAN_SPLIT;
		end
		// Once offsets of zero are dropped the candidates are in ascending order, so the
		// back end need not sort.
		unique case (hello.func)
			tlshsp_pkg::FUNC_SNI_MID: begin
				entry.cand[0]   = mid_w;
				entry.cand_mask = 4'b0001;
			end
			tlshsp_pkg::FUNC_RECORD_1: begin
				entry.cand[0]   = tlshsp_pkg::FIRST_BYTE;
				entry.cand_mask = 4'b0001;
			end
			tlshsp_pkg::FUNC_SNI_PRE: begin
				entry.cand[0]   = start_w;
				entry.cand_mask = 4'b0001;
			end
			tlshsp_pkg::FUNC_SNI_MULTI: begin
				entry.cand[0]   = tlshsp_pkg::FIRST_BYTE;
				entry.cand[1]   = start_w;
				entry.cand[2]   = mid_w;
				entry.cand[3]   = end_w;
				entry.cand_mask = 4'b1111;
			end
			tlshsp_pkg::FUNC_SNI_MID_SLOW: begin
				entry.cand[0]   = mid_w;
				entry.cand_mask = 4'b0001;
				entry.chunk     = tlshsp_pkg::SLOW_CHUNK;
				entry.delay     = slow_delay;
			end
			default: begin
				entry.cand_mask = '0;
			end
		endcase
	end

endmodule

// File: sv/tlshsp_queue.sv
module tlshsp_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tlshsp_pkg::plan_entry_t     push_entry,
	input  logic                        pop,
	output tlshsp_pkg::plan_entry_t     head,
	output tlshsp_pkg::q_status_t       status
);

	tlshsp_pkg::plan_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/tlshsp_back.sv
module tlshsp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlshsp_pkg::plan_entry_t     head,
	input  tlshsp_pkg::q_status_t       q_status,
	output logic                        pop,
	tlshsp_out_if.source                plan
);

	logic [tlshsp_pkg::MAX_SPLITS-1:0]  keep;
	logic [tlshsp_pkg::SPLIT_W-1:0]     slots [tlshsp_pkg::MAX_SPLITS];
	logic [tlshsp_pkg::COUNT_W-1:0]     nkept;
	logic                               ok;
	logic                               load;
	logic                               valid_q;
	logic                               accepted_q;
	logic [tlshsp_pkg::COUNT_W-1:0]     count_q;
	logic [tlshsp_pkg::SPLIT_W-1:0]     split_q [tlshsp_pkg::MAX_SPLITS];
	logic [tlshsp_pkg::CHUNK_W-1:0]     chunk_q;
	logic [tlshsp_pkg::DELAY_W-1:0]     delay_q;

	assign load = !valid_q || plan.ready;
	assign pop  = load && !q_status.empty;

	// A candidate equal to any earlier one is a repeat: the earlier twin is either kept
	// already or lies out of range, and then so does this one.
	always_comb begin
		for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
			keep[i] = head.cand_mask[i] && (head.cand[i] != '0) &&
				(head.cand[i] < {1'b0, head.plen});
			for (int j = 0; j < i; j++) begin
				if (head.cand_mask[j] && (head.cand[i] == head.cand[j])) begin
					keep[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		nkept = '0;
		for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
			slots[i] = '0;
		end
		for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
			if (keep[i]) begin
				slots[nkept[1:0]] = head.cand[i][tlshsp_pkg::SPLIT_W-1:0];
				nkept = nkept + 3'd1;
			end
		end
	end

	assign ok = (nkept != '0) || (head.chunk != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.kind)
				tlshsp_pkg::PLAN_SPLIT: begin
					accepted_q <= ok;
					count_q    <= nkept;
					for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
						split_q[i] <= slots[i];
					end
					chunk_q <= head.chunk;
					delay_q <= head.delay;
				end
				tlshsp_pkg::PLAN_PASS, tlshsp_pkg::PLAN_REJECT: begin
					accepted_q <= head.kind == tlshsp_pkg::PLAN_PASS;
					count_q    <= '0;
					for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
						split_q[i] <= '0;
					end
					chunk_q <= '0;
					delay_q <= '0;
				end
				default: begin
					accepted_q <= 1'b0;
					count_q    <= '0;
					for (int i = 0; i < tlshsp_pkg::MAX_SPLITS; i++) begin
						split_q[i] <= '0;
					end
					chunk_q <= '0;
					delay_q <= '0;
				end
			endcase
		end
	end

	assign plan.valid       = valid_q;
	assign plan.accepted    = accepted_q;
	assign plan.split_count = count_q;
	assign plan.split_a     = split_q[0];
	assign plan.split_b     = split_q[1];
	assign plan.split_c     = split_q[2];
	assign plan.split_d     = split_q[3];
	assign plan.write_chunk = chunk_q;
	assign plan.delay_ms    = delay_q;

endmodule

// File: sv/tls_hello_split_planner.sv
// A hello is written into the queue, then popped into the registered output stage.
// Throughput: one hello per cycle while plan.ready is high; the front end classifies,
// a two-entry queue and a registered output stage decouple it from the back end that
// filters and packs splits. Reset (arst_n low, asynchronous) empties the queue and
// output stage and sets base_delay_ms to zero; no clearing pass is needed.
module tls_hello_split_planner (
	input  logic          clk,
	input  logic          arst_n,
	tlshsp_in_if.sink     hello,
	tlshsp_out_if.source  plan,
	tlshsp_cfg_if.sink    cfg
);

	logic [tlshsp_pkg::BASE_W-1:0] base_delay_q;
	logic                          push;
	logic                          pop;
	tlshsp_pkg::plan_entry_t       push_entry;
	tlshsp_pkg::plan_entry_t       head;
	tlshsp_pkg::q_status_t         q_status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q <= '0;
		end else if (cfg.valid) begin
			base_delay_q <= cfg.base_delay_ms;
		end
	end

	tlshsp_front u_front (
		.hello      (hello),
		.base_delay (base_delay_q),
		.q_status   (q_status),
		.push       (push),
		.entry      (push_entry)
	);

	tlshsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	tlshsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.plan     (plan)
	);

	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && !plan.accepted |-> plan.split_count == 3'd0)
		else $error("rejected plan carries splits");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && plan.split_count == 3'd0 |-> plan.split_a == 14'd0)
		else $error("unused split slot not zero");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && plan.split_count >= 3'd2 |-> plan.split_a < plan.split_b)
		else $error("splits not strictly ascending");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && (hello.ready == !q_status.full))
		else $error("queue status inconsistent with input ready");

endmodule

// File: dv/testbench.sv
module testbench;
	import tlshsp_pkg::*;

	localparam int unsigned RUN_LIMIT = 4000000;
	localparam int unsigned PHASE_ITEMS = 235;
	localparam int unsigned REPORT_CAP = 50;
	localparam logic [3:0] FUNC_UNUSED_FIRST = FUNC_SNI_MID_SLOW + 4'd1;
	localparam logic [3:0] FUNC_UNUSED_LAST = 4'hF;

	typedef struct {
		logic [3:0]  func;
		logic        spans_records;
		logic        has_sni;
		logic [14:0] sni_offset;
		logic [7:0]  sni_length;
		logic [14:0] payload_length;
	} hello_t;

	typedef struct packed {
		logic                           accepted;
		logic [COUNT_W-1:0]             split_count;
		logic [MAX_SPLITS-1:0][SPLIT_W-1:0] split;
		logic [CHUNK_W-1:0]             write_chunk;
		logic [DELAY_W-1:0]             delay_ms;
	} plan_t;

	class plan_scoreboard;
		logic [BASE_W-1:0] base_delay;
		plan_t awaited[$];
		int unsigned errors;

		function new();
			base_delay = '0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < REPORT_CAP)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		// Works out the split plan for one hello under the current base delay.
		function plan_t plan_for(hello_t h);
			plan_t p;
			int unsigned cuts[$];
			int unsigned kept[$];
			int unsigned limit, start, mid, stop, slow, v, pos;
			bit needs_sni, dup;
			p = '0;
			if (h.func > FUNC_SNI_MID_SLOW)
				return p;
			if (h.func == FUNC_NONE || h.func == FUNC_PACKET_ALT ||
					(h.func >= FUNC_PACKET_FIRST && h.func <= FUNC_PACKET_LAST)) begin
				p.accepted = 1'b1;
				return p;
			end
			needs_sni = h.func == FUNC_SNI_MID || h.func == FUNC_SNI_PRE ||
				h.func == FUNC_SNI_MULTI || h.func == FUNC_SNI_MID_SLOW;
			if (h.spans_records || (needs_sni && !h.has_sni) || h.payload_length < MIN_PAYLOAD)
				return p;
			limit = (h.payload_length > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(h.payload_length);
			start = (h.has_sni && h.sni_offset >= HDR_BYTES) ?
				int'(h.sni_offset) - int'(HDR_BYTES) : 0;
			mid = start + h.sni_length / 2;
			stop = start + h.sni_length;
			p.delay_ms = DELAY_W'(base_delay);
			case (h.func)
				FUNC_SNI_MID: cuts.insert(cuts.size(), mid);
				FUNC_RECORD_1: cuts.insert(cuts.size(), int'(FIRST_BYTE));
				FUNC_SNI_PRE: cuts.insert(cuts.size(), start);
				FUNC_SNI_MULTI: begin
					cuts.insert(cuts.size(), int'(FIRST_BYTE));
					cuts.insert(cuts.size(), start);
					cuts.insert(cuts.size(), mid);
					cuts.insert(cuts.size(), stop);
				end
				default: begin
					cuts.insert(cuts.size(), mid);
					p.write_chunk = SLOW_CHUNK;
					slow = 2 * int'(base_delay);
					if (slow < int'(SLOW_MIN_DELAY))
						slow = int'(SLOW_MIN_DELAY);
					p.delay_ms = DELAY_W'(slow);
				end
			endcase
			foreach (cuts[i]) begin
				v = cuts[i];
				if (v < 1 || v >= limit)
					continue;
				dup = 1'b0;
				pos = 0;
				foreach (kept[j]) begin
					if (kept[j] == v)
						dup = 1'b1;
					if (kept[j] < v)
						pos = j + 1;
				end
				if (!dup)
					kept.insert(pos, v);
			end
			p.accepted = kept.size() > 0 || p.write_chunk != 0;
			p.split_count = COUNT_W'(kept.size());
			foreach (kept[i])
				p.split[i] = SPLIT_W'(kept[i]);
			return p;
		endfunction

		function void note_hello(hello_t h);
			awaited.insert(awaited.size(), plan_for(h));
		endfunction

		task check_plan(plan_t got);
			plan_t want;
			if (awaited.size() == 0) begin
				report("plan item with no hello awaiting it");
				return;
			end
			want = awaited.pop_front();
			if (got.accepted !== want.accepted)
				report($sformatf("accepted: want %0d got %0d", want.accepted, got.accepted));
			if (got.split_count !== want.split_count)
				report($sformatf("split_count: want %0d got %0d",
					want.split_count, got.split_count));
			for (int i = 0; i < MAX_SPLITS; i++)
				if (got.split[i] !== want.split[i])
					report($sformatf("split %0d: want %0d got %0d", i,
						want.split[i], got.split[i]));
			if (got.write_chunk !== want.write_chunk)
				report($sformatf("write_chunk: want %0d got %0d",
					want.write_chunk, got.write_chunk));
			if (got.delay_ms !== want.delay_ms)
				report($sformatf("delay_ms: want %0d got %0d", want.delay_ms, got.delay_ms));
		endtask

		task check_drained();
			if (awaited.size() != 0)
				report($sformatf("%0d plans never arrived", awaited.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit tame;
	int unsigned calm_items;
	plan_scoreboard sb;

	tlshsp_in_if hello_if();
	tlshsp_out_if plan_if();
	tlshsp_cfg_if cfg_if();

	tls_hello_split_planner dut (
		.clk(clk),
		.arst_n(arst_n),
		.hello(hello_if),
		.plan(plan_if),
		.cfg(cfg_if)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#RUN_LIMIT;
		$display("tls_hello_split_planner regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		hello_t h;
		plan_t got;
		if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
			sb.base_delay = cfg_if.base_delay_ms;
		if (hello_if.valid === 1'b1 && hello_if.ready === 1'b1) begin
			h.func = hello_if.func;
			h.spans_records = hello_if.spans_records;
			h.has_sni = hello_if.has_sni;
			h.sni_offset = hello_if.sni_offset;
			h.sni_length = hello_if.sni_length;
			h.payload_length = hello_if.payload_length;
			sb.note_hello(h);
		end
		if (plan_if.valid === 1'b1 && plan_if.ready === 1'b1) begin
			got.accepted = plan_if.accepted;
			got.split_count = plan_if.split_count;
			got.split[0] = plan_if.split_a;
			got.split[1] = plan_if.split_b;
			got.split[2] = plan_if.split_c;
			got.split[3] = plan_if.split_d;
			got.write_chunk = plan_if.write_chunk;
			got.delay_ms = plan_if.delay_ms;
			sb.check_plan(got);
		end
	end

	// The receiver stalls in bursts, with long stretches of steady readiness between.
	initial begin
		plan_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!tame) begin
				case ($urandom_range(0, 59))
					0: repeat ($urandom_range(20, 80)) @(posedge clk);
					1, 2, 3, 4, 5, 6: begin
						plan_if.ready <= 1'b0;
						repeat ($urandom_range(1, 14)) @(posedge clk);
						plan_if.ready <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	function automatic void add_hello(ref hello_t q[$], input hello_t h);
		q.insert(q.size(), h);
	endfunction

	task automatic send_hello(hello_t h);
		hello_if.valid <= 1'b1;
		hello_if.func <= h.func;
		hello_if.spans_records <= h.spans_records;
		hello_if.has_sni <= h.has_sni;
		hello_if.sni_offset <= h.sni_offset;
		hello_if.sni_length <= h.sni_length;
		hello_if.payload_length <= h.payload_length;
		do @(posedge clk); while (hello_if.ready !== 1'b1);
	endtask

	task automatic hello_pause();
		if (tame)
			return;
		if (calm_items != 0) begin
			calm_items--;
			return;
		end
		case ($urandom_range(0, 39))
			0: calm_items = $urandom_range(20, 60);
			1, 2, 3, 4, 5, 6, 7: begin
				hello_if.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			default: ;
		endcase
	endtask

	task automatic send_batch(hello_t batch[$]);
		foreach (batch[i]) begin
			send_hello(batch[i]);
			if (i != batch.size() - 1)
				hello_pause();
		end
		hello_if.valid <= 1'b0;
	endtask

	// The first edge lets the monitor note the last item before the count is read.
	task automatic wait_drained();
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	task automatic write_base_delay(logic [BASE_W-1:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.base_delay_ms <= v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic hello_t random_hello();
		hello_t h;
		int unsigned limit;
		if ($urandom_range(0, 99) < 15) begin
			h.func = 4'($urandom);
			h.spans_records = 1'($urandom);
			h.has_sni = 1'($urandom);
			h.sni_offset = 15'($urandom);
			h.sni_length = 8'($urandom);
			h.payload_length = 15'($urandom);
			return h;
		end
		case ($urandom_range(0, 11))
			0, 1: h.func = FUNC_SNI_MID;
			2: h.func = FUNC_RECORD_1;
			3, 4: h.func = FUNC_SNI_PRE;
			5, 6, 7: h.func = FUNC_SNI_MULTI;
			8, 9: h.func = FUNC_SNI_MID_SLOW;
			10: case ($urandom_range(0, 2))
				0: h.func = FUNC_NONE;
				1: h.func = FUNC_PACKET_FIRST +
					4'($urandom_range(0, FUNC_PACKET_LAST - FUNC_PACKET_FIRST));
				default: h.func = FUNC_PACKET_ALT;
			endcase
			default: h.func = 4'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
		endcase
		h.spans_records = $urandom_range(0, 19) == 0;
		h.has_sni = $urandom_range(0, 14) != 0;
		case ($urandom_range(0, 9))
			0: h.payload_length = 15'($urandom_range(0, 3));
			1: h.payload_length = 15'($urandom_range(16300, 16384));
			2: h.payload_length = 15'($urandom_range(16385, 32767));
			default: h.payload_length = 15'($urandom_range(2, 700));
		endcase
		// Hostname starts up to ten bytes past the record end, so splits fall on both sides.
		limit = (h.payload_length > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(h.payload_length);
		if ($urandom_range(0, 9) == 0)
			h.sni_offset = 15'($urandom_range(0, 6));
		else
			h.sni_offset = 15'(int'(HDR_BYTES) + $urandom_range(0, limit + 10));
		h.sni_length = 8'($urandom);
		return h;
	endfunction

	initial begin
		hello_t directed[$];
		hello_t batch[$];
		logic [BASE_W-1:0] settings[$];

		sb = new();
		tame = 1'b0;
		calm_items = 0;
		arst_n <= 1'b0;
		hello_if.valid <= 1'b0;
		hello_if.func <= FUNC_NONE;
		hello_if.spans_records <= 1'b0;
		hello_if.has_sni <= 1'b0;
		hello_if.sni_offset <= '0;
		hello_if.sni_length <= '0;
		hello_if.payload_length <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.base_delay_ms <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Passthrough and unknown profiles, the first and last with all other fields at top.
		add_hello(directed, '{FUNC_NONE, 1'b1, 1'b1, 15'h7FFF, 8'hFF, 15'h7FFF});
		for (int f = FUNC_PACKET_FIRST; f <= FUNC_PACKET_LAST; f++)
			add_hello(directed, '{4'(f), 1'b0, 1'b0, 15'd0, 8'd0, 15'd0});
		add_hello(directed, '{FUNC_PACKET_ALT, 1'b1, 1'b0, 15'd9, 8'd3, 15'd1});
		add_hello(directed, '{FUNC_UNUSED_FIRST, 1'b0, 1'b1, 15'd45, 8'd20, 15'd300});
		add_hello(directed, '{FUNC_UNUSED_LAST, 1'b1, 1'b1, 15'h7FFF, 8'hFF, 15'h7FFF});
		// Plain sni-mid, then each of the early exits.
		add_hello(directed, '{FUNC_SNI_MID, 1'b0, 1'b1, 15'd45, 8'd20, 15'd300});
		add_hello(directed, '{FUNC_SNI_MID, 1'b1, 1'b1, 15'd45, 8'd20, 15'd300});
		add_hello(directed, '{FUNC_SNI_MID, 1'b0, 1'b0, 15'd45, 8'd20, 15'd300});
		add_hello(directed, '{FUNC_SNI_MID, 1'b0, 1'b1, 15'd45, 8'd20, 15'd1});
		add_hello(directed, '{FUNC_SNI_MID, 1'b0, 1'b1, 15'd45, 8'd20, 15'd0});
		// The shortest record still takes the first-byte split; the name is not needed.
		add_hello(directed, '{FUNC_RECORD_1, 1'b0, 1'b0, 15'd700, 8'd9, 15'd2});
		// Hostname offsets inside the header clamp to zero, which leaves nothing to cut.
		add_hello(directed, '{FUNC_SNI_PRE, 1'b0, 1'b1, 15'd3, 8'd0, 15'd50});
		add_hello(directed, '{FUNC_SNI_PRE, 1'b0, 1'b1, 15'd5, 8'd4, 15'd50});
		// Oversized record: only the split at the very end of the clamped length fits.
		add_hello(directed, '{FUNC_SNI_PRE, 1'b0, 1'b1, 15'd16388, 8'd2, 15'h7FFF});
		add_hello(directed, '{FUNC_SNI_PRE, 1'b0, 1'b1, 15'd16389, 8'd2, 15'd16384});
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b1, 15'h7FFF, 8'hFF, 15'h7FFF});
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b1, 15'd6, 8'd0, 15'd100});
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b1, 15'd105, 8'd200, 15'd1000});
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b0, 15'd105, 8'd200, 15'd1000});
		// A hostname at the record start puts its middle on the first byte.
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b1, 15'd5, 8'd3, 15'd100});
		add_hello(directed, '{FUNC_SNI_MULTI, 1'b0, 1'b1, 15'd2, 8'd1, 15'd100});
		// The slow profile stays usable on its chunk size alone.
		add_hello(directed, '{FUNC_SNI_MID_SLOW, 1'b0, 1'b1, 15'd500, 8'd40, 15'd2});
		add_hello(directed, '{FUNC_SNI_MID_SLOW, 1'b0, 1'b1, 15'd50, 8'd255, 15'd16384});
		send_batch(directed);

		settings.insert(settings.size(), 16'hFFFF);
		settings.insert(settings.size(), 16'd0);
		settings.insert(settings.size(), 16'(SLOW_MIN_DELAY / 2 - 1));
		settings.insert(settings.size(), 16'(SLOW_MIN_DELAY / 2));
		settings.insert(settings.size(), 16'(SLOW_MIN_DELAY / 2 + 1));
		settings.insert(settings.size(), 16'($urandom));
		settings.insert(settings.size(), 16'($urandom));
		settings.insert(settings.size(), 16'd1);
		foreach (settings[p]) begin
			wait_drained();
			write_base_delay(settings[p]);
			if (p == settings.size() - 1)
				tame = 1'b1;
			batch.delete();
			repeat (PHASE_ITEMS)
				add_hello(batch, random_hello());
			// The directed items run again under the first setting, the highest delay.
			if (p == 0)
				foreach (directed[i])
					add_hello(batch, directed[i]);
			send_batch(batch);
		end

		wait_drained();
		repeat (6) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("tls_hello_split_planner regression: pass");
		else
			$display("tls_hello_split_planner regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/tlshsp_pkg.sv
sv/tlshsp_ifs.sv
sv/tlshsp_front.sv
sv/tlshsp_queue.sv
sv/tlshsp_back.sv
sv/tls_hello_split_planner.sv
dv/testbench.sv
